FILE: src/frame_bitmap_allocator_macros.svh
// assertion macros for the frame bitmap allocator checker
// needs clk and rst_n in the scope of use
`ifndef FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define FRAME_BITMAP_ALLOCATOR_MACROS_SVH

// antecedent holds, consequent in the next cycle
`define FBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame allocator check failed");

// antecedent holds, consequent in the same cycle
`define FBA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame allocator check failed");

`endif

FILE: src/fba_pkg.sv
// shared types and constants of the frame bitmap allocator
// no dependencies
package fba_pkg;

    localparam int NUM_FRAMES       = 262144;
    localparam int BASE_FRAME_BYTES = 67108864;
    localparam int FRAME_BYTES      = 4096;

    localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
    localparam int BASE_FRAME  = BASE_FRAME_BYTES / FRAME_BYTES;
    localparam int FRAME_W     = 19;
    localparam int WORD_BITS   = 32;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int NUM_WORDS   = NUM_FRAMES / WORD_BITS;
    localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
    localparam int CFG_W       = 40;
    localparam int ADDR_IN_W   = 32;
    localparam int ADDR_OUT_W  = 30;
    localparam int OP_W        = 2;

    localparam logic [CFG_W:0] MAX_BYTES =
        (CFG_W + 1)'(longint'(NUM_FRAMES) * longint'(FRAME_BYTES));
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64'h4000_0000);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_BIT,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_INIT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic scan_rd;
        logic scan_step;
        logic mark_rd;
        logic mark_wr;
        logic free_rd;
        logic free_wr;
        logic sweep_wr;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic zero_len;
        logic fail_cond;
        logic found;
        logic word_end;
        logic mark_last;
        logic free_ok;
        logic sweep_last;
        logic out_free;
    } sts_t;

endpackage

FILE: src/frame_bitmap_allocator.sv
// top level of the frame bitmap allocator
// depends on fba_pkg, fba_ctrl, fba_datapath
//
//  channel | handshake          | payload
//  in      | in_valid/in_ready  | operation, run_length, free_address
//  out     | out_valid/out_ready| status, frame_address, free_count, total_frames
//  cfg     | cfg_wr_en          | cfg_wr_data (memory top in bytes)
//
// allocate scans one frame a cycle, pausing to read each new 32-frame word, then
// marks the run with a read and a write per word; free reads, then clears the bit
// initialize sweeps the bitmap memory, one 32-frame word a cycle (8192 words)
// after reset the same sweep marks every frame used; no word is taken meanwhile
// a finished result waits in the output register while the next word is taken
module frame_bitmap_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [fba_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [fba_pkg::OP_W-1:0]       operation,
    input  logic [fba_pkg::FRAME_W-1:0]    run_length,
    input  logic [fba_pkg::ADDR_IN_W-1:0]  free_address,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           status,
    output logic [fba_pkg::ADDR_OUT_W-1:0] frame_address,
    output logic [fba_pkg::FRAME_W-1:0]    free_count,
    output logic [fba_pkg::FRAME_W-1:0]    total_frames
);

    fba_pkg::cmd_t cmd;
    fba_pkg::sts_t sts;

    fba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fba_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .operation     (operation),
        .run_length    (run_length),
        .free_address  (free_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .frame_address (frame_address),
        .free_count    (free_count),
        .total_frames  (total_frames),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

FILE: src/fba_ram.sv
// generic simple dual port ram with registered read
// no dependencies
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/fba_ctrl.sv
// sequencer of the frame bitmap allocator
// depends on fba_pkg
module fba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  fba_pkg::sts_t sts,
    output fba_pkg::cmd_t cmd
);

    fba_pkg::state_t state_reg;
    fba_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fba_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            fba_pkg::ST_CLEAR:
            begin
                cmd.sweep_wr = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = fba_pkg::ST_IDLE;
                end
            end
            fba_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (sts.op)
                        fba_pkg::OP_ALLOC:
                        begin
                            state_next = sts.zero_len ? fba_pkg::ST_RESP : fba_pkg::ST_SCAN_RD;
                        end
                        fba_pkg::OP_FREE: state_next = fba_pkg::ST_FREE_RD;
                        fba_pkg::OP_INIT: state_next = fba_pkg::ST_INIT;
                        default:          state_next = fba_pkg::ST_RESP;
                    endcase
                end
            end
            fba_pkg::ST_SCAN_RD:
            begin
                if (sts.fail_cond)
                begin
                    state_next = fba_pkg::ST_RESP;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = fba_pkg::ST_SCAN_BIT;
                end
            end
            fba_pkg::ST_SCAN_BIT:
            begin
                if (sts.fail_cond)
                begin
                    state_next = fba_pkg::ST_RESP;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (sts.found)
                    begin
                        state_next = fba_pkg::ST_MARK_RD;
                    end
                    else if (sts.word_end)
                    begin
                        state_next = fba_pkg::ST_SCAN_RD;
                    end
                end
            end
            fba_pkg::ST_MARK_RD:
            begin
                cmd.mark_rd = 1'b1;
                state_next  = fba_pkg::ST_MARK_WR;
            end
            fba_pkg::ST_MARK_WR:
            begin
                cmd.mark_wr = 1'b1;
                state_next  = sts.mark_last ? fba_pkg::ST_RESP : fba_pkg::ST_MARK_RD;
            end
            fba_pkg::ST_FREE_RD:
            begin
                if (sts.free_ok)
                begin
                    cmd.free_rd = 1'b1;
                    state_next  = fba_pkg::ST_FREE_WR;
                end
                else
                begin
                    state_next = fba_pkg::ST_RESP;
                end
            end
            fba_pkg::ST_FREE_WR:
            begin
                cmd.free_wr = 1'b1;
                state_next  = fba_pkg::ST_RESP;
            end
            fba_pkg::ST_INIT:
            begin
                cmd.sweep_wr = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = fba_pkg::ST_RESP;
                end
            end
            fba_pkg::ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = fba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fba_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/fba_datapath.sv
// bitmap memory, scan pointers, counters and result register
// depends on fba_pkg and fba_ram
module fba_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [fba_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic [fba_pkg::OP_W-1:0]         operation,
    input  logic [fba_pkg::FRAME_W-1:0]      run_length,
    input  logic [fba_pkg::ADDR_IN_W-1:0]    free_address,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             status,
    output logic [fba_pkg::ADDR_OUT_W-1:0]   frame_address,
    output logic [fba_pkg::FRAME_W-1:0]      free_count,
    output logic [fba_pkg::FRAME_W-1:0]      total_frames,
    input  fba_pkg::cmd_t                    cmd,
    output fba_pkg::sts_t                    sts
);

    localparam int FW = fba_pkg::FRAME_W;
    localparam int WW = fba_pkg::WORD_IDX_W;
    localparam int BW = fba_pkg::BIT_W;
    localparam logic [FW-1:0] BASE_F = FW'(fba_pkg::BASE_FRAME);

    logic [fba_pkg::CFG_W-1:0] cfg_reg;
    logic [FW-1:0]             f_reg;
    logic [FW-1:0]             s_reg;
    logic [FW-1:0]             r_reg;
    logic [FW-1:0]             n_reg;
    logic [FW-1:0]             top_reg;
    logic [FW-1:0]             cnt_reg;
    logic [WW-1:0]             sweep_reg;
    logic                      free_ok_reg;
    logic                      status_reg;
    logic [fba_pkg::ADDR_OUT_W-1:0] addr_reg;
    logic                      out_valid_reg;
    logic                      out_status_reg;
    logic [fba_pkg::ADDR_OUT_W-1:0] out_addr_reg;
    logic [FW-1:0]             out_free_reg;
    logic [FW-1:0]             out_total_reg;

    logic [fba_pkg::WORD_BITS-1:0] rd_data;
    logic [fba_pkg::WORD_BITS-1:0] wr_data;
    logic [WW-1:0]                 wr_addr;
    logic                          wr_en;
    logic [WW-1:0]                 f_word;
    logic [BW-1:0]                 f_bit;
    logic [FW:0]                   e_sum;
    logic [FW:0]                   next_word_start;
    logic [fba_pkg::WORD_BITS-1:0] sweep_mask;
    logic [fba_pkg::WORD_BITS-1:0] mark_mask;
    logic [fba_pkg::CFG_W:0]       clamp_bytes;
    logic [FW-1:0]                 init_top;
    logic [fba_pkg::ADDR_IN_W-1:0] free_frame;
    logic                          bit_used;
    logic [FW-1:0]                 sw_fr;
    logic [FW-1:0]                 mk_fr;

    assign f_word          = f_reg[WW+BW-1:BW];
    assign f_bit           = f_reg[BW-1:0];
    assign e_sum           = {1'b0, s_reg} + {1'b0, n_reg};
    assign next_word_start = (FW+1)'({1'b0, f_word} + 1'b1) << BW;
    assign bit_used        = rd_data[f_bit];
    assign clamp_bytes     = ({1'b0, cfg_reg} > fba_pkg::MAX_BYTES) ?
                             fba_pkg::MAX_BYTES : {1'b0, cfg_reg};
    assign init_top        = FW'(clamp_bytes >> fba_pkg::FRAME_SHIFT);
    assign free_frame      = free_address >> fba_pkg::FRAME_SHIFT;

    always_comb
    begin
        sweep_mask = '0;
        mark_mask  = '0;
        sw_fr      = '0;
        mk_fr      = '0;
        for (int j = 0; j < fba_pkg::WORD_BITS; j++)
        begin
            sw_fr = FW'({sweep_reg, BW'(j)});
            mk_fr = FW'({f_word, BW'(j)});
            sweep_mask[j] = !(sw_fr >= BASE_F && sw_fr < top_reg);
            mark_mask[j]  = (mk_fr >= s_reg) && ({1'b0, mk_fr} < e_sum);
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = f_word;
        wr_data = rd_data;
        if (cmd.sweep_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_reg;
            wr_data = sweep_mask;
        end
        else if (cmd.mark_wr)
        begin
            wr_en   = 1'b1;
            wr_data = rd_data | mark_mask;
        end
        else if (cmd.free_wr)
        begin
            wr_en   = bit_used;
            wr_data = rd_data & ~(fba_pkg::WORD_BITS'(1) << f_bit);
        end
    end

    fba_ram #(
        .WIDTH (fba_pkg::WORD_BITS),
        .DEPTH (fba_pkg::NUM_WORDS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.scan_rd | cmd.mark_rd | cmd.free_rd),
        .rd_addr (f_word),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= fba_pkg::CFG_RESET;
            top_reg       <= '0;
            cnt_reg       <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            if (cmd.capture && fba_pkg::op_t'(operation) == fba_pkg::OP_INIT)
            begin
                top_reg <= init_top;
                cnt_reg <= (init_top > BASE_F) ? init_top - BASE_F : '0;
            end
            if (cmd.sweep_wr)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.scan_step && sts.found)
            begin
                cnt_reg <= cnt_reg - n_reg;
            end
            if (cmd.free_wr && bit_used)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            n_reg       <= run_length;
            s_reg       <= BASE_F;
            r_reg       <= '0;
            addr_reg    <= '0;
            free_ok_reg <= free_frame < fba_pkg::ADDR_IN_W'(fba_pkg::NUM_FRAMES);
            status_reg  <= !(fba_pkg::op_t'(operation) == fba_pkg::OP_FREE ||
                             fba_pkg::op_t'(operation) == fba_pkg::OP_INIT);
            f_reg       <= (fba_pkg::op_t'(operation) == fba_pkg::OP_FREE) ?
                           FW'(free_frame) : BASE_F;
        end
        if (cmd.scan_step)
        begin
            if (sts.found)
            begin
                status_reg <= 1'b0;
                addr_reg   <= fba_pkg::ADDR_OUT_W'(
                              fba_pkg::ADDR_IN_W'(s_reg) << fba_pkg::FRAME_SHIFT);
                f_reg      <= s_reg;
            end
            else
            begin
                f_reg <= f_reg + 1'b1;
                if (bit_used)
                begin
                    s_reg <= f_reg + 1'b1;
                    r_reg <= '0;
                end
                else
                begin
                    r_reg <= r_reg + 1'b1;
                end
            end
        end
        if (cmd.mark_wr)
        begin
            f_reg <= FW'(next_word_start);
        end
        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_addr_reg   <= addr_reg;
            out_free_reg   <= cnt_reg;
            out_total_reg  <= top_reg;
        end
    end

    always_comb
    begin
        sts            = '0;
        sts.op         = fba_pkg::op_t'(operation);
        sts.zero_len   = (run_length == '0);
        sts.fail_cond  = e_sum > {1'b0, top_reg};
        sts.found      = !bit_used && ({1'b0, r_reg} + 1'b1 == {1'b0, n_reg});
        sts.word_end   = (f_bit == '1);
        sts.mark_last  = next_word_start >= e_sum;
        sts.free_ok    = free_ok_reg;
        sts.sweep_last = (sweep_reg == '1);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign frame_address = out_addr_reg;
    assign free_count    = out_free_reg;
    assign total_frames  = out_total_reg;

endmodule

FILE: src/fba_checker.sv
// port level checks of the frame bitmap allocator, bound to the top level
// depends on fba_pkg and frame_bitmap_allocator_macros.svh
`include "frame_bitmap_allocator_macros.svh"

module fba_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           status,
    input logic [fba_pkg::ADDR_OUT_W-1:0] frame_address,
    input logic [fba_pkg::FRAME_W-1:0]    free_count
);

    `FBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(free_count))
    `FBA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `FBA_ASSERT_SAME(a_fail_no_addr, out_valid && status, frame_address == '0)

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .frame_address (frame_address),
    .free_count    (free_count)
);
